FILE: src/pffm_pkg.sv
// Shared constants, types and helpers for the pulldown field frame mapper.
package pffm_pkg;

   localparam int INDEX_BITS  = 24;
   localparam int SRC_BITS    = 24;
   localparam int MAX_FRAMES  = 3;
   localparam int FCNT_BITS   = $clog2(MAX_FRAMES + 1);
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);
   localparam int MODE_BITS   = 2;
   localparam int BAL_BITS    = 4;

   localparam logic [MODE_BITS-1:0] MODE_HONOR = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_FILM  = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_RAW   = 2'd2;

   localparam logic signed [BAL_BITS-1:0] THR_UNLOCKED = 4'sd3;
   localparam logic signed [BAL_BITS-1:0] THR_LOCKED   = 4'sd5;

   typedef struct packed {
      logic [SRC_BITS-1:0] top;
      logic [SRC_BITS-1:0] bot;
   } frame_type;

   typedef struct packed {
      logic [FCNT_BITS-1:0]              count;
      logic                              repeats;
      frame_type [MAX_FRAMES-1:0]        frames;
   } job_type;

   typedef struct packed {
      logic                 full;
      logic                 empty;
      logic [QCNT_BITS-1:0] used;
   } queue_status_type;

   function automatic logic [SRC_BITS-1:0] to_src(input logic [INDEX_BITS-1:0] idx);
      return SRC_BITS'(idx);
   endfunction

endpackage

FILE: src/pffm_front.sv
// Front end: takes coded picture beats, tracks field state, builds frame jobs.
module pffm_front
   import pffm_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_en,
   input  logic [MODE_BITS-1:0] csr_write_data,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_top_first,
   input  logic                 req_repeat_first,
   input  logic                 req_progressive_pic,
   input  queue_status_type     queue_status,
   output logic                 push_valid,
   output job_type              push_job
);

   logic [MODE_BITS-1:0]         field_mode_ff;
   logic [INDEX_BITS-1:0]        coded_index_ff, coded_index_in;
   logic signed [BAL_BITS-1:0]   balance_ff, balance_in;
   logic                         locked_ff, locked_in;
   logic                         top_pend_ff, top_pend_in;
   logic                         bot_pend_ff, bot_pend_in;
   logic [SRC_BITS-1:0]          entry_top_ff, entry_top_in;
   logic [SRC_BITS-1:0]          entry_bot_ff, entry_bot_in;
   logic                         repeats_ff, repeats_in;

   logic                         accept;
   logic [SRC_BITS-1:0]          cur;
   logic                         rff;
   logic                         honor;
   logic signed [BAL_BITS-1:0]   thr;
   logic signed [BAL_BITS-1:0]   bal_step;
   job_type                      job;

   assign req_ready = !queue_status.full;
   assign accept    = req_valid && req_ready;

   always_comb begin
      cur   = to_src(coded_index_ff);
      rff   = req_repeat_first && (field_mode_ff != MODE_RAW);
      honor = (field_mode_ff != MODE_FILM) && (field_mode_ff != MODE_RAW);
      thr   = locked_ff ? THR_LOCKED : THR_UNLOCKED;

      coded_index_in = coded_index_ff + INDEX_BITS'(1);
      repeats_in     = repeats_ff | (honor & req_repeat_first);
      balance_in     = balance_ff;
      locked_in      = locked_ff;
      top_pend_in    = top_pend_ff;
      bot_pend_in    = bot_pend_ff;
      entry_top_in   = entry_top_ff;
      entry_bot_in   = entry_bot_ff;
      bal_step       = balance_ff;

      job.count   = '0;
      job.repeats = repeats_in;
      for (int i = 0; i < MAX_FRAMES; i++) begin
         job.frames[i].top = cur;
         job.frames[i].bot = cur;
      end

      if (field_mode_ff == MODE_FILM) begin
         // step the repeat/no-repeat balance, drop or double at the threshold
         bal_step   = rff ? balance_ff - BAL_BITS'(1) : balance_ff + BAL_BITS'(1);
         balance_in = bal_step;
         if (bal_step == thr) begin
            balance_in = '0;
            locked_in  = 1'b1;
         end else begin
            job.count = FCNT_BITS'(1);
         end
         if (bal_step == -thr) begin
            balance_in = '0;
            locked_in  = 1'b1;
            job.count  = FCNT_BITS'(2);
         end
      end else if (req_progressive_pic) begin
         job.count = FCNT_BITS'(1) + FCNT_BITS'(rff) + FCNT_BITS'(rff & req_top_first);
      end else begin
         job.count = FCNT_BITS'(1);
         if (top_pend_ff) begin
            job.frames[0].top = entry_top_ff;
            entry_top_in      = cur;
         end else if (bot_pend_ff) begin
            job.frames[0].bot = entry_bot_ff;
            entry_bot_in      = cur;
         end
         if (rff) begin
            if (req_top_first) begin
               entry_top_in = cur;
               top_pend_in  = 1'b1;
            end else begin
               entry_bot_in = cur;
               bot_pend_in  = 1'b1;
            end
            if (top_pend_in && bot_pend_in) begin
               top_pend_in       = 1'b0;
               bot_pend_in       = 1'b0;
               job.frames[1].top = entry_top_in;
               job.frames[1].bot = entry_bot_in;
               job.count         = FCNT_BITS'(2);
            end
         end
      end
   end

   assign push_valid = accept && (job.count != '0);
   assign push_job   = job;

   always_ff @(posedge clock) begin
      if (reset) begin
         field_mode_ff  <= MODE_HONOR;
         coded_index_ff <= '0;
         balance_ff     <= '0;
         locked_ff      <= 1'b0;
         top_pend_ff    <= 1'b0;
         bot_pend_ff    <= 1'b0;
         entry_top_ff   <= '0;
         entry_bot_ff   <= '0;
         repeats_ff     <= 1'b0;
      end else begin
         if (csr_write_en) begin
            field_mode_ff <= csr_write_data;
         end
         if (accept) begin
            coded_index_ff <= coded_index_in;
            balance_ff     <= balance_in;
            locked_ff      <= locked_in;
            top_pend_ff    <= top_pend_in;
            bot_pend_ff    <= bot_pend_in;
            entry_top_ff   <= entry_top_in;
            entry_bot_ff   <= entry_bot_in;
            repeats_ff     <= repeats_in;
         end
      end
   end

endmodule

FILE: src/pffm_queue.sv
// Short job queue between the front end and the frame emitter.
module pffm_queue
   import pffm_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   input  job_type          push_job,
   input  logic             pop,
   output job_type          head_job,
   output queue_status_type status
);

   job_type                mem_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0]   used_ff, used_in;
   logic                   do_push;
   logic                   do_pop;

   assign status.full  = (used_ff == QCNT_BITS'(QUEUE_DEPTH));
   assign status.empty = (used_ff == '0);
   assign status.used  = used_ff;
   assign head_job     = mem_ff[rd_ptr_ff];

   assign do_push = push_valid && !status.full;
   assign do_pop  = pop && !status.empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      used_in   = used_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                                : wr_ptr_ff + QPTR_BITS'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                                : rd_ptr_ff + QPTR_BITS'(1);
      end
      if (do_push && !do_pop) begin
         used_in = used_ff + QCNT_BITS'(1);
      end else if (do_pop && !do_push) begin
         used_in = used_ff - QCNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         used_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         used_ff   <= used_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

FILE: src/pffm_back.sv
// Back end: plays out the frames of each job, one result beat per cycle while rsp_ready is high.
module pffm_back
   import pffm_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  job_type             head_job,
   input  queue_status_type    queue_status,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [SRC_BITS-1:0] rsp_top_source,
   output logic [SRC_BITS-1:0] rsp_bottom_source,
   output logic                rsp_last_of_run,
   output logic                rsp_repeats_present
);

   job_type               job_ff;
   logic                  valid_ff;
   logic [FCNT_BITS-1:0]  idx_ff;
   logic                  last;
   logic                  done;

   assign last = (idx_ff == job_ff.count - FCNT_BITS'(1));
   // free the job register when empty or when its final beat leaves
   assign done = !valid_ff || (rsp_ready && last);
   assign pop  = done && !queue_status.empty;

   assign rsp_valid           = valid_ff;
   assign rsp_top_source      = job_ff.frames[idx_ff].top;
   assign rsp_bottom_source   = job_ff.frames[idx_ff].bot;
   assign rsp_last_of_run     = last;
   assign rsp_repeats_present = job_ff.repeats;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else if (done) begin
         valid_ff <= !queue_status.empty;
         idx_ff   <= '0;
      end else if (rsp_ready) begin
         idx_ff <= idx_ff + FCNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         job_ff <= head_job;
      end
   end

endmodule

FILE: src/pulldown_field_frame_mapper.sv
// Top level of the pulldown field frame mapper: front end, job queue, frame emitter.
// A picture's first result beat passes the queue memory and the emitter's job register.
// Throughput: one req beat per cycle while the two-entry job queue has room; the emitter
//   sends one frame per cycle while rsp_ready is high; a picture yields 0 to 3 frames.
// Reset: synchronous, active high; clears counter, cadence, field state, mode and queue.
module pulldown_field_frame_mapper
   import pffm_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_en,
   input  logic [MODE_BITS-1:0] csr_write_data,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_top_first,
   input  logic                 req_repeat_first,
   input  logic                 req_progressive_pic,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [SRC_BITS-1:0]  rsp_top_source,
   output logic [SRC_BITS-1:0]  rsp_bottom_source,
   output logic                 rsp_last_of_run,
   output logic                 rsp_repeats_present
);

   logic             push_valid;
   job_type          push_job;
   logic             pop;
   job_type          head_job;
   queue_status_type queue_status;

   // Front end: classify each picture, update field pairing and cadence state,
   // and push a job holding every frame it completes (dropped pictures push nothing).
   pffm_front u_front (
      .clock               (clock),
      .reset               (reset),
      .csr_write_en        (csr_write_en),
      .csr_write_data      (csr_write_data),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_top_first       (req_top_first),
      .req_repeat_first    (req_repeat_first),
      .req_progressive_pic (req_progressive_pic),
      .queue_status        (queue_status),
      .push_valid          (push_valid),
      .push_job            (push_job)
   );

   // Job queue: decouples picture intake from frame playout.
   pffm_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push_valid (push_valid),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .status   (queue_status)
   );

   // Frame emitter: hold one job, advance one frame per accepted beat.
   pffm_back u_back (
      .clock               (clock),
      .reset               (reset),
      .head_job            (head_job),
      .queue_status        (queue_status),
      .pop                 (pop),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_top_source      (rsp_top_source),
      .rsp_bottom_source   (rsp_bottom_source),
      .rsp_last_of_run     (rsp_last_of_run),
      .rsp_repeats_present (rsp_repeats_present)
   );

   // A job is never pushed into a full queue.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push_valid |-> !queue_status.full)
      else $error("job pushed into full queue");

   // Occupancy stays within the queue depth.
   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      queue_status.used <= QCNT_BITS'(QUEUE_DEPTH))
      else $error("queue occupancy out of range");

   // The repeat flag is sticky across beats in order.
   a_repeats_sticky: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_repeats_present) |=> (!rsp_valid || rsp_repeats_present))
      else $error("repeats_present dropped");

   // Pop only when the emitter frees its job register.
   a_pop_when_free: assert property (@(posedge clock) disable iff (reset)
      pop |-> (!rsp_valid || (rsp_ready && rsp_last_of_run)))
      else $error("job popped while emitter busy");

endmodule
